/* sv/prrf_pkg.sv */
`timescale 1ns / 1ps
package prrf_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int ENTRY_BITS_DEF = 32;

	// reserve register and drop counter have fixed widths
	localparam int RES_W   = 9;
	localparam logic [RES_W-1:0] RES_RESET = 9'd32;
	localparam int DROP_W  = 32;

	// apb port
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;
	localparam int REG_IDX_W = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_PRIORITY_RESERVE = 1'b0;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef struct packed {
		logic done;
		logic pop_ok;
	} res_flags_t;

endpackage

/* sv/priority_reserve_ring_fifo.sv */
`timescale 1ns / 1ps
// Non-blocking ring fifo with a priority reserve. Each request is a push or a
// pop and yields exactly one result: pushes are refused (and counted in
// drop_total) when the fifo is full, or for normal entries when no more than
// priority_reserve slots remain; a pop on an empty fifo returns done_res 0
// instead of waiting. Entries live in a synchronous ram with a registered read,
// so a result passes from the s1 stage into the output register, and
// one request per cycle is taken while results are drained. Pointers and
// counters sit in flops next to the ram; no clearing pass follows reset.
module priority_reserve_ring_fifo #(
	parameter int DEPTH      = prrf_pkg::DEPTH_DEF,
	parameter int ENTRY_BITS = prrf_pkg::ENTRY_BITS_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [prrf_pkg::APB_AW-1:0]  paddr,
	input  logic [prrf_pkg::APB_DW-1:0]  pwdata,
	output logic [prrf_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic                         is_priority,
	input  logic [ENTRY_BITS-1:0]        entry_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         done_res,
	output logic [ENTRY_BITS-1:0]        popped_data,
	output logic [CNT_W-1:0]             fill_count,
	output logic [CNT_W-1:0]             peak_fill,
	output logic [prrf_pkg::DROP_W-1:0]  drop_total
);

	logic [prrf_pkg::RES_W-1:0]     reserve_q;
	logic [prrf_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           cfg_wr;

	logic                        accept, advance;
	logic                        ram_we, ram_re;
	logic [PTR_W-1:0]            ram_waddr, ram_raddr;
	logic [ENTRY_BITS-1:0]       ram_wdata, ram_rdata;
	logic                        valid_s1;
	prrf_pkg::res_flags_t        flags_s1;
	logic [CNT_W-1:0]            fill_s1, peak_s1;
	logic [prrf_pkg::DROP_W-1:0] drop_s1;
	logic                        out_valid_q;

	// configuration
	assign pready  = 1'b1;
	assign reg_idx = paddr[prrf_pkg::APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_q <= prrf_pkg::RES_RESET;
		end else if (cfg_wr && (reg_idx == prrf_pkg::REG_PRIORITY_RESERVE)) begin
			reserve_q <= pwdata[prrf_pkg::RES_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (psel && (reg_idx == prrf_pkg::REG_PRIORITY_RESERVE)) begin
			prdata = prrf_pkg::APB_DW'(reserve_q);
		end
	end

	// handshake: s1 moves to the output register when that is free or drained
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	prrf_ctrl #(
		.DEPTH      (DEPTH),
		.ENTRY_BITS (ENTRY_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.advance     (advance),
		.action      (action),
		.is_priority (is_priority),
		.entry_data  (entry_data),
		.reserve     (reserve_q),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.valid_s1    (valid_s1),
		.flags_s1    (flags_s1),
		.fill_s1     (fill_s1),
		.peak_s1     (peak_s1),
		.drop_s1     (drop_s1)
	);

	prrf_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_res    <= flags_s1.done;
			popped_data <= flags_s1.pop_ok ? ram_rdata : '0;
			fill_count  <= fill_s1;
			peak_fill   <= peak_s1;
			drop_total  <= drop_s1;
		end
	end

	assign out_valid = out_valid_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_count <= CNT_W'(DEPTH)))
		else $error("fill count above depth");

	a_peak_covers_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (peak_fill >= fill_count))
		else $error("peak below fill count");

	a_failed_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !done_res) |-> (popped_data == '0))
		else $error("data on a failed request");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with free pipeline");

endmodule

/* sv/prrf_ram.sv */
`timescale 1ns / 1ps
module prrf_ram #(
	parameter int WIDTH = prrf_pkg::ENTRY_BITS_DEF,
	parameter int DEPTH = prrf_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/prrf_ctrl.sv */
`timescale 1ns / 1ps
module prrf_ctrl #(
	parameter int DEPTH      = prrf_pkg::DEPTH_DEF,
	parameter int ENTRY_BITS = prrf_pkg::ENTRY_BITS_DEF,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        advance,
	input  logic                        action,
	input  logic                        is_priority,
	input  logic [ENTRY_BITS-1:0]       entry_data,
	input  logic [prrf_pkg::RES_W-1:0]  reserve,
	output logic                        ram_we,
	output logic [PTR_W-1:0]            ram_waddr,
	output logic [ENTRY_BITS-1:0]       ram_wdata,
	output logic                        ram_re,
	output logic [PTR_W-1:0]            ram_raddr,
	output logic                        valid_s1,
	output prrf_pkg::res_flags_t        flags_s1,
	output logic [CNT_W-1:0]            fill_s1,
	output logic [CNT_W-1:0]            peak_s1,
	output logic [prrf_pkg::DROP_W-1:0] drop_s1
);

	localparam int SUM_W = ((CNT_W > prrf_pkg::RES_W) ? CNT_W : prrf_pkg::RES_W) + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [PTR_W-1:0]            wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]            occ_q, peak_q;
	logic [prrf_pkg::DROP_W-1:0] drop_q;

	logic [SUM_W-1:0] occ_plus_res;
	logic             full;
	logic             push_ok, pop_ok, push_drop;
	logic [CNT_W-1:0] occ_next, peak_next;
	logic [prrf_pkg::DROP_W-1:0] drop_next;

	always_comb begin
		occ_plus_res = SUM_W'(occ_q) + SUM_W'(reserve);
		if (is_priority) begin
			full = (occ_q >= CNT_W'(DEPTH));
		end else begin
			full = (occ_plus_res >= SUM_W'(DEPTH));
		end
		push_ok   = accept && (action == prrf_pkg::ACT_PUSH) && !full;
		push_drop = accept && (action == prrf_pkg::ACT_PUSH) && full;
		pop_ok    = accept && (action == prrf_pkg::ACT_POP) && (occ_q != '0);

		occ_next = occ_q;
		if (push_ok) begin
			occ_next = occ_q + 1'b1;
		end else if (pop_ok) begin
			occ_next = occ_q - 1'b1;
		end
		peak_next = (occ_next > peak_q) ? occ_next : peak_q;
		drop_next = push_drop ? drop_q + 1'b1 : drop_q;
	end

	assign ram_we    = push_ok;
	assign ram_waddr = wr_ptr_q;
	assign ram_wdata = entry_data;
	assign ram_re    = pop_ok;
	assign ram_raddr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			peak_q   <= '0;
			drop_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			occ_q  <= occ_next;
			peak_q <= peak_next;
			drop_q <= drop_next;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// result fields of the request now waiting on the ram read
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1.done   <= push_ok || pop_ok;
			flags_s1.pop_ok <= pop_ok;
			fill_s1         <= occ_next;
			peak_s1         <= peak_next;
			drop_s1         <= drop_next;
		end
	end

endmodule
